FILE: rtl/sscon_pkg.sv
package sscon_pkg;

  // Field widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW   = 31;
  localparam int unsigned MagW   = 33;  // |a - b| fits 33 bits unsigned
  localparam int unsigned SqW    = 66;  // sum of three squares
  localparam int unsigned RootW  = 33;  // floor(sqrt) of a 66-bit value
  localparam int unsigned RemW   = 35;  // square root partial remainder
  localparam int unsigned NormW  = 16;
  localparam int unsigned QW     = 17;  // normal quotient before saturation
  localparam int unsigned NumW   = 48;  // |d| * 2^15 + len / 2

  localparam logic [QW-1:0]    QSat   = 17'd32768;
  localparam logic [NormW-1:0] NormMax = 16'h7fff;

  // One classified pair as it sits in the queue
  typedef struct packed {
    logic                        hit;
    logic [CoordW-1:0]           depth;
    logic [RootW-1:0]            len;
    logic [2:0][MagW-1:0]        mag;
    logic [2:0]                  neg;
    logic [2:0][CoordW-1:0]      mid;
  } item_t;

endpackage

FILE: rtl/sscon_ram.sv
module sscon_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sscon_front.sv
module sscon_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [31:0]         a_x_i,
  input  logic [31:0]         a_y_i,
  input  logic [31:0]         a_z_i,
  input  logic [30:0]         a_radius_i,
  input  logic [31:0]         b_x_i,
  input  logic [31:0]         b_y_i,
  input  logic [31:0]         b_z_i,
  input  logic [30:0]         b_radius_i,
  output logic                wr_valid_o,
  output sscon_pkg::item_t    wr_item_o
);

  localparam int unsigned NS = sscon_pkg::RootW;

  logic [31:0] a_c [3];
  logic [31:0] b_c [3];

  assign a_c[0] = a_x_i;
  assign a_c[1] = a_y_i;
  assign a_c[2] = a_z_i;
  assign b_c[0] = b_x_i;
  assign b_c[1] = b_y_i;
  assign b_c[2] = b_z_i;

  // Stage 1: midline, magnitudes, midpoints, radius sum (kept in depth)
  sscon_pkg::item_t s1_d, s1_q;
  logic             s1_v_q;

  always_comb begin
    logic [32:0] dif;
    logic [32:0] sum;
    s1_d = '0;
    for (int i = 0; i < 3; i++) begin
      dif = {a_c[i][31], a_c[i]} - {b_c[i][31], b_c[i]};
      sum = {a_c[i][31], a_c[i]} + {b_c[i][31], b_c[i]};
      s1_d.neg[i] = dif[32];
      s1_d.mag[i] = dif[32] ? (~dif + 33'd1) : dif;
      s1_d.mid[i] = sum[32:1];
    end
    s1_d.depth = {1'b0, a_radius_i} + {1'b0, b_radius_i};
  end

  // Stage 2: squares
  sscon_pkg::item_t     s2_q;
  logic                 s2_v_q;
  logic [sscon_pkg::SqW-1:0] sq_q [3];

  // Square root pipeline, index 0 is the sum-of-squares register
  logic                         v_q    [NS+1];
  logic [sscon_pkg::SqW-1:0]    n_q    [NS+1];
  logic [sscon_pkg::RootW-1:0]  root_q [NS+1];
  logic [sscon_pkg::RemW-1:0]   rem_q  [NS+1];
  sscon_pkg::item_t             pay_q  [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      v_q[0] <= 1'b0;
    end else begin
      s1_v_q <= acc_i;
      s2_v_q <= s1_v_q;
      v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s1_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= s1_q.mag[i] * s1_q.mag[i];
    end
    n_q[0]    <= sq_q[0] + sq_q[1] + sq_q[2];
    root_q[0] <= '0;
    rem_q[0]  <= '0;
    pay_q[0]  <= s2_q;
  end

  // One root bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [sscon_pkg::RemW+1:0]  rem_x;
    logic [sscon_pkg::RootW+1:0] trial;
    logic                        ge;
    logic [sscon_pkg::RemW+1:0]  rem_n;

    always_comb begin
      rem_x = {rem_q[k], n_q[k][2*(NS-1-k)+1 -: 2]};
      trial = {root_q[k], 2'b01};
      ge    = rem_x >= {{(sscon_pkg::RemW-sscon_pkg::RootW){1'b0}}, trial};
      rem_n = ge ? (rem_x - {{(sscon_pkg::RemW-sscon_pkg::RootW){1'b0}}, trial}) : rem_x;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[k+1]    <= n_q[k];
      root_q[k+1] <= {root_q[k][sscon_pkg::RootW-2:0], ge};
      rem_q[k+1]  <= rem_n[sscon_pkg::RemW-1:0];
      pay_q[k+1]  <= pay_q[k];
    end
  end

  // Classify: hit when length does not exceed the radius sum
  always_comb begin
    logic [31:0] rsum;
    logic [sscon_pkg::RootW-1:0] len;
    rsum      = pay_q[NS].depth;
    len       = root_q[NS];
    wr_item_o = pay_q[NS];
    wr_item_o.len   = len;
    wr_item_o.hit   = {1'b0, rsum} >= len;
    wr_item_o.depth = rsum - len[31:0];
  end

  assign wr_valid_o = v_q[NS];

endmodule

FILE: rtl/sscon_back.sv
module sscon_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  output logic                pop_o,
  input  sscon_pkg::item_t    rd_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic [15:0]         normal_x_o,
  output logic [15:0]         normal_y_o,
  output logic [15:0]         normal_z_o,
  output logic [31:0]         depth_o,
  output logic [31:0]         contact_x_o,
  output logic [31:0]         contact_y_o,
  output logic [31:0]         contact_z_o
);

  localparam int unsigned ND = sscon_pkg::QW;
  localparam int unsigned RW = sscon_pkg::RootW;
  localparam int unsigned NW = sscon_pkg::NumW;

  logic adv;
  logic out_v_q;

  // Whole back pipe moves when the output register is free or taken
  assign adv   = !out_v_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  // Stage 0 is the queue read register
  logic rd_v_q;

  // Prep stage: dividend and overflow check, index 0 of the divider pipe
  logic                  v_q    [ND+1];
  sscon_pkg::item_t      pay_q  [ND+1];
  logic [NW-1:0]         num_q  [ND+1][3];
  logic [2:0]            ovf_q  [ND+1];
  logic [RW-1:0]         rem_q  [ND+1][3];
  logic [ND-1:0]         q_q    [ND+1][3];

  logic [NW-1:0] num_d [3];
  logic [2:0]    ovf_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = {rd_item_i.mag[i], 15'd0} + {{(NW-RW+1){1'b0}}, rd_item_i.len[RW-1:1]};
      ovf_d[i] = {2'b00, num_d[i][NW-1:ND]} >= rd_item_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (adv) begin
      rd_v_q <= !empty_i;
      v_q[0] <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pay_q[0] <= rd_item_i;
      ovf_q[0] <= ovf_d;
      for (int i = 0; i < 3; i++) begin
        num_q[0][i] <= num_d[i];
        rem_q[0][i] <= {2'b00, num_d[i][NW-1:ND]};
        q_q[0][i]   <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per stage and lane
  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [RW-1:0] rem_n [3];
    logic [2:0]    ge;

    always_comb begin
      logic [RW:0] rx;
      for (int i = 0; i < 3; i++) begin
        rx       = {rem_q[j][i], num_q[j][i][ND-1-j]};
        ge[i]    = rx >= {1'b0, pay_q[j].len};
        rem_n[i] = ge[i] ? rx[RW-1:0] - pay_q[j].len : rx[RW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (adv) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pay_q[j+1] <= pay_q[j];
        ovf_q[j+1] <= ovf_q[j];
        for (int i = 0; i < 3; i++) begin
          num_q[j+1][i] <= num_q[j][i];
          rem_q[j+1][i] <= rem_n[i];
          q_q[j+1][i]   <= {q_q[j][i][ND-2:0], ge[i]};
        end
      end
    end
  end

  // Format: saturate, apply sign, zero everything on a miss
  sscon_pkg::item_t fin;
  logic [15:0] nrm_d [3];
  logic [15:0] nrm_q [3];
  logic        hit_q;
  logic [31:0] depth_q;
  logic [31:0] mid_q [3];

  assign fin = pay_q[ND];

  always_comb begin
    logic [ND-1:0] qs;
    logic [ND-1:0] qn;
    for (int i = 0; i < 3; i++) begin
      qs = (ovf_q[ND][i] || q_q[ND][i] > sscon_pkg::QSat) ? sscon_pkg::QSat : q_q[ND][i];
      qn = ~qs + 17'd1;
      if (!fin.hit || fin.len == '0) begin
        nrm_d[i] = '0;
      end else if (fin.neg[i]) begin
        nrm_d[i] = qn[15:0];
      end else if (qs > {1'b0, sscon_pkg::NormMax}) begin
        nrm_d[i] = sscon_pkg::NormMax;
      end else begin
        nrm_d[i] = qs[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v_q[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q   <= fin.hit;
      depth_q <= fin.hit ? fin.depth : '0;
      for (int i = 0; i < 3; i++) begin
        nrm_q[i] <= nrm_d[i];
        mid_q[i] <= fin.hit ? fin.mid[i] : '0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign hit_o       = hit_q;
  assign normal_x_o  = nrm_q[0];
  assign normal_y_o  = nrm_q[1];
  assign normal_z_o  = nrm_q[2];
  assign depth_o     = depth_q;
  assign contact_x_o = mid_q[0];
  assign contact_y_o = mid_q[1];
  assign contact_z_o = mid_q[2];

endmodule

FILE: rtl/sphere_sphere_contact_top.sv
// Sphere pair contact unit. Takes one pair of spheres (Q16.16 centers and radii) per
// clock and returns one word per pair: hit flag, Q1.15 unit normal from B toward A,
// penetration depth and the midpoint of the centers; all fields are zero on a miss.
// The front computes the midline, its squared length and a 33-stage square root and
// writes classified pairs to a queue; the back runs a 17-stage divider per normal
// lane. Throughput is one pair per clock: input ready drops only once 2**QUEUE_AW
// pairs are in the front pipe or the queue, so QUEUE_AW must keep the queue deeper
// than the 36-cycle front pipe.
module sphere_sphere_contact_top #(
  parameter int unsigned QUEUE_AW = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] a_x_i,
  input  logic [31:0] a_y_i,
  input  logic [31:0] a_z_i,
  input  logic [30:0] a_radius_i,
  input  logic [31:0] b_x_i,
  input  logic [31:0] b_y_i,
  input  logic [31:0] b_z_i,
  input  logic [30:0] b_radius_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [15:0] normal_x_o,
  output logic [15:0] normal_y_o,
  output logic [15:0] normal_z_o,
  output logic [31:0] depth_o,
  output logic [31:0] contact_x_o,
  output logic [31:0] contact_y_o,
  output logic [31:0] contact_z_o
);

  localparam int unsigned Depth = 1 << QUEUE_AW;

  logic                 acc;
  logic                 wr_valid;
  sscon_pkg::item_t     wr_item;
  sscon_pkg::item_t     rd_item;
  logic                 pop;
  logic                 empty;
  logic [QUEUE_AW:0]    wp_q, wp_d;
  logic [QUEUE_AW:0]    rp_q, rp_d;
  logic [QUEUE_AW:0]    cnt_q, cnt_d;

  // Credits cover pairs in the front pipe plus those queued
  assign in_ready_o = cnt_q != Depth[QUEUE_AW:0];
  assign acc        = in_valid_i && in_ready_o;
  assign empty      = wp_q == rp_q;

  always_comb begin
    wp_d  = wr_valid ? wp_q + 1'b1 : wp_q;
    rp_d  = pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + {{QUEUE_AW{1'b0}}, acc} - {{QUEUE_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  sscon_front u_front (
    .clk_i,
    .rst_ni,
    .acc_i      (acc),
    .a_x_i,
    .a_y_i,
    .a_z_i,
    .a_radius_i,
    .b_x_i,
    .b_y_i,
    .b_z_i,
    .b_radius_i,
    .wr_valid_o (wr_valid),
    .wr_item_o  (wr_item)
  );

  sscon_ram #(
    .Width ($bits(sscon_pkg::item_t)),
    .Depth (Depth)
  ) u_queue (
    .clk_i,
    .we_i    (wr_valid),
    .waddr_i (wp_q[QUEUE_AW-1:0]),
    .wdata_i (wr_item),
    .re_i    (pop),
    .raddr_i (rp_q[QUEUE_AW-1:0]),
    .rdata_o (rd_item)
  );

  sscon_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i     (empty),
    .pop_o       (pop),
    .rd_item_i   (rd_item),
    .out_valid_o,
    .out_ready_i,
    .hit_o,
    .normal_x_o,
    .normal_y_o,
    .normal_z_o,
    .depth_o,
    .contact_x_o,
    .contact_y_o,
    .contact_z_o
  );

  // Credit count never exceeds the queue depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth[QUEUE_AW:0])
    else $error("credit count overflow");

  // Queue occupancy stays within the credits handed out
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q - rp_q) <= cnt_q)
    else $error("queue holds more than credited");

  // The queue never overflows on a front write
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid |-> ((wp_q - rp_q) != Depth[QUEUE_AW:0]))
    else $error("queue written while full");

endmodule
